// ----- design/tabular_q_learning_engine_assert.svh -----
// assertion macros for the q-learning engine
// TQLE_ASSERT: property checked on every rising clk edge outside reset
// TQLE_ASSERT_NEXT: antecedent in one cycle implies consequent in the next
`ifndef TABULAR_Q_LEARNING_ENGINE_ASSERT_SVH
`define TABULAR_Q_LEARNING_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
`define TQLE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("tqle assertion failed");
`define TQLE_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error("tqle assertion failed");
`else
`define TQLE_ASSERT(lbl, prop)
`define TQLE_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ----- design/tqle_pkg.sv -----
package tqle_pkg;

	localparam int STATE_COUNT = 65536;
	localparam int ACTION_COUNT = 4;
	localparam int TABLE_DEPTH = STATE_COUNT * ACTION_COUNT;

	localparam int ST_W = $clog2(STATE_COUNT);
	localparam int ACT_W = $clog2(ACTION_COUNT);
	localparam int IDX_W = $clog2(TABLE_DEPTH);

	localparam int STATE_FIELD_W = 16;
	localparam int REWARD_W = 8;
	localparam int SCALE_W = 17;
	localparam int ACT_FIELD_W = 2;
	localparam int Q_W = 32;

	localparam int FRAC_W = 16;
	localparam int ONE_Q16 = 65536;
	localparam int HALF_Q16 = 32768;
	localparam int DISCOUNT_RESET = 64881;

	localparam int MUL_A_W = SCALE_W + 1;
	localparam int DELTA_W = 34;
	localparam int MUL_P_W = MUL_A_W + DELTA_W;
	localparam int SUM_W = 36;

	typedef struct packed {
		logic [STATE_FIELD_W-1:0] state_index;
		logic signed [REWARD_W-1:0] reward;
		logic [SCALE_W-1:0] learning_rate;
		logic is_final;
		logic learn_enable;
		logic explore;
		logic [ACT_FIELD_W-1:0] random_action;
	} obs_t;

	typedef struct packed {
		logic [ACT_FIELD_W-1:0] action;
		logic signed [Q_W-1:0] action_value;
	} res_t;

	function automatic logic [IDX_W-1:0] pair_of(logic [ACT_W-1:0] a, logic [ST_W-1:0] s);
		return IDX_W'(IDX_W'(a) * IDX_W'(STATE_COUNT) + IDX_W'(s));
	endfunction

	function automatic logic [SCALE_W-1:0] clamp_one(logic [SCALE_W-1:0] v);
		return (v > SCALE_W'(ONE_Q16)) ? SCALE_W'(ONE_Q16) : v;
	endfunction

endpackage

// ----- design/tabular_q_learning_engine.sv -----
// channel  | signals                     | moves
// ---------+-----------------------------+------------------------------------
// obs      | obs_valid, obs_ready, obs   | one observation per transaction
// res      | res_valid, res_ready, res   | action and its value per transaction
// cfg      | cfg_we, cfg_wdata           | discount factor write, no wait
//
// after reset the table is cleared one entry a cycle with obs_ready low; states per step:
// play-only SCAN, DRAIN, DONE; learning RDQ, WTQ, SCAN, DRAIN, MUL1, ADD, MUL2, WR, SCAN,
// DRAIN, DONE; terminal learning RDQ, WTQ, ADD, MUL2, WR; terminal without update IDLE only
// a finished result waits in the output register while the next observation is taken
// a stalled result holds the engine in its last step until the register frees
`include "tabular_q_learning_engine_assert.svh"

module tabular_q_learning_engine (
	input  logic clk,
	input  logic arst_n,
	input  logic obs_valid,
	output logic obs_ready,
	input  tqle_pkg::obs_t obs,
	output logic res_valid,
	input  logic res_ready,
	output tqle_pkg::res_t res,
	input  logic cfg_we,
	input  logic [tqle_pkg::SCALE_W-1:0] cfg_wdata
);

	typedef enum logic [10:0] {
		S_CLEAR = 11'b000_0000_0001,
		S_IDLE  = 11'b000_0000_0010,
		S_RDQ   = 11'b000_0000_0100,
		S_WTQ   = 11'b000_0000_1000,
		S_SCAN  = 11'b000_0001_0000,
		S_DRAIN = 11'b000_0010_0000,
		S_MUL1  = 11'b000_0100_0000,
		S_ADD   = 11'b000_1000_0000,
		S_MUL2  = 11'b001_0000_0000,
		S_WR    = 11'b010_0000_0000,
		S_DONE  = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	logic [tqle_pkg::Q_W-1:0] mem_q [tqle_pkg::TABLE_DEPTH];
	logic [tqle_pkg::Q_W-1:0] mem_rd_q;
	logic mem_we;
	logic [tqle_pkg::IDX_W-1:0] mem_wa;
	logic [tqle_pkg::IDX_W-1:0] mem_ra;
	logic [tqle_pkg::Q_W-1:0] mem_wd;

	logic [tqle_pkg::IDX_W-1:0] clr_cnt_q;
	logic [tqle_pkg::SCALE_W-1:0] discount_q;
	logic [tqle_pkg::IDX_W-1:0] last_idx_q;
	logic last_vld_q;

	logic [tqle_pkg::ST_W-1:0] state_idx_q;
	logic signed [tqle_pkg::REWARD_W-1:0] reward_q;
	logic [tqle_pkg::SCALE_W-1:0] alpha_q;
	logic final_q;
	logic explore_q;
	logic [tqle_pkg::ACT_W-1:0] rnd_q;
	logic pass2_q;

	logic [tqle_pkg::ACT_W-1:0] scan_cnt_q;
	logic rd_scan_q;
	logic [tqle_pkg::ACT_W-1:0] rd_act_q;
	logic signed [tqle_pkg::Q_W-1:0] best_q;
	logic [tqle_pkg::ACT_W-1:0] best_act_q;
	logic signed [tqle_pkg::Q_W-1:0] rnd_val_q;
	logic signed [tqle_pkg::Q_W-1:0] q_q;

	logic signed [tqle_pkg::MUL_A_W-1:0] mul_a;
	logic signed [tqle_pkg::DELTA_W-1:0] mul_b;
	logic signed [tqle_pkg::MUL_P_W-1:0] mul_q;
	logic signed [tqle_pkg::MUL_P_W-1:0] prod_rnd;
	logic signed [tqle_pkg::DELTA_W-1:0] target;
	logic signed [tqle_pkg::DELTA_W-1:0] delta_q;
	logic signed [tqle_pkg::SUM_W-1:0] new_sum;
	logic [tqle_pkg::Q_W-1:0] new_q;

	logic obs_acc;
	logic res_free;
	logic upd;
	logic [tqle_pkg::ST_W-1:0] obs_state;
	logic [tqle_pkg::ACT_W-1:0] obs_rnd;
	logic [tqle_pkg::ACT_W-1:0] pick_act;
	logic signed [tqle_pkg::Q_W-1:0] pick_val;

	assign obs_ready = (state_q == S_IDLE);
	assign obs_acc = obs_valid && obs_ready;
	assign res_free = !res_valid || res_ready;
	assign upd = obs.learn_enable && last_vld_q;

	assign obs_state = ({1'b0, obs.state_index} >= (tqle_pkg::STATE_FIELD_W+1)'(tqle_pkg::STATE_COUNT))
		? tqle_pkg::ST_W'(tqle_pkg::STATE_COUNT - 1) : tqle_pkg::ST_W'(obs.state_index);
	assign obs_rnd = (int'(obs.random_action) >= tqle_pkg::ACTION_COUNT)
		? tqle_pkg::ACT_W'(tqle_pkg::ACTION_COUNT - 1) : tqle_pkg::ACT_W'(obs.random_action);

	assign pick_act = explore_q ? rnd_q : best_act_q;
	assign pick_val = explore_q ? rnd_val_q : best_q;

	// table port
	always_comb begin
		mem_ra = (state_q == S_RDQ) ? last_idx_q : tqle_pkg::pair_of(scan_cnt_q, state_idx_q);
		mem_we = 1'b0;
		mem_wa = last_idx_q;
		mem_wd = new_q;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_cnt_q;
			mem_wd = '0;
		end else if (state_q == S_WR) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		mem_rd_q <= mem_q[mem_ra];
	end

	// shared multiplier and rounding
	always_comb begin
		if (state_q == S_MUL2) begin
			mul_a = $signed({1'b0, alpha_q});
			mul_b = delta_q;
		end else begin
			mul_a = $signed({1'b0, tqle_pkg::clamp_one(discount_q)});
			mul_b = tqle_pkg::DELTA_W'(best_q);
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	assign prod_rnd = (mul_q + $signed(tqle_pkg::MUL_P_W'(tqle_pkg::HALF_Q16))) >>> tqle_pkg::FRAC_W;

	always_comb begin
		target = tqle_pkg::DELTA_W'(reward_q) <<< tqle_pkg::FRAC_W;
		if (!final_q) begin
			target = target + tqle_pkg::DELTA_W'(prod_rnd);
		end
	end

	assign new_sum = tqle_pkg::SUM_W'(q_q) + tqle_pkg::SUM_W'(prod_rnd);

	always_comb begin
		if ((&new_sum[tqle_pkg::SUM_W-1:tqle_pkg::Q_W-1]) ||
			!(|new_sum[tqle_pkg::SUM_W-1:tqle_pkg::Q_W-1])) begin
			new_q = new_sum[tqle_pkg::Q_W-1:0];
		end else if (new_sum[tqle_pkg::SUM_W-1]) begin
			new_q = {1'b1, {(tqle_pkg::Q_W-1){1'b0}}};
		end else begin
			new_q = {1'b0, {(tqle_pkg::Q_W-1){1'b1}}};
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (obs_acc) begin
			state_idx_q <= obs_state;
			reward_q <= obs.reward;
			alpha_q <= tqle_pkg::clamp_one(obs.learning_rate);
			final_q <= obs.is_final;
			explore_q <= obs.explore;
			rnd_q <= obs_rnd;
		end
		if (state_q == S_WTQ) begin
			q_q <= $signed(mem_rd_q);
		end
		if (state_q == S_ADD) begin
			delta_q <= target - tqle_pkg::DELTA_W'(q_q);
		end
		rd_act_q <= scan_cnt_q;
		if (rd_scan_q) begin
			if ((rd_act_q == '0) || ($signed(mem_rd_q) > best_q)) begin
				best_q <= $signed(mem_rd_q);
				best_act_q <= rd_act_q;
			end
			if (rd_act_q == rnd_q) begin
				rnd_val_q <= $signed(mem_rd_q);
			end
		end
		if ((state_q == S_DONE) && res_free) begin
			res.action <= tqle_pkg::ACT_FIELD_W'(pick_act);
			res.action_value <= pick_val;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_cnt_q <= '0;
			discount_q <= tqle_pkg::SCALE_W'(tqle_pkg::DISCOUNT_RESET);
			last_idx_q <= '0;
			last_vld_q <= 1'b0;
			pass2_q <= 1'b0;
			scan_cnt_q <= '0;
			rd_scan_q <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				discount_q <= cfg_wdata;
			end
			if ((state_q == S_DONE) && res_free) begin
				res_valid <= 1'b1;
			end else if (res_valid && res_ready) begin
				res_valid <= 1'b0;
			end
			rd_scan_q <= (state_q == S_SCAN);
			if (state_q != S_SCAN) begin
				scan_cnt_q <= '0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == tqle_pkg::IDX_W'(tqle_pkg::TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (obs_acc) begin
						if (upd) begin
							state_q <= S_RDQ;
						end else if (obs.is_final) begin
							last_vld_q <= 1'b0;
						end else begin
							pass2_q <= 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				S_RDQ: begin
					state_q <= S_WTQ;
				end
				S_WTQ: begin
					if (final_q) begin
						state_q <= S_ADD;
					end else begin
						pass2_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
					if (scan_cnt_q == tqle_pkg::ACT_W'(tqle_pkg::ACTION_COUNT - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= pass2_q ? S_DONE : S_MUL1;
				end
				S_MUL1: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (final_q) begin
						last_vld_q <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						pass2_q <= 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_DONE: begin
					if (res_free) begin
						last_idx_q <= tqle_pkg::pair_of(pick_act, state_idx_q);
						last_vld_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`TQLE_ASSERT(a_wr_needs_pair, (state_q == S_WR) |-> last_vld_q)
	`TQLE_ASSERT(a_drain_after_scan, (state_q == S_DRAIN) |-> ($past(state_q) == S_SCAN))
	`TQLE_ASSERT_NEXT(a_play_only_scans, obs_acc && !obs.is_final && !upd, (state_q == S_SCAN) && pass2_q)
	`TQLE_ASSERT_NEXT(a_final_drops_pair, obs_acc && obs.is_final && !upd, !last_vld_q && (state_q == S_IDLE))
	`TQLE_ASSERT_NEXT(a_result_records_pair, (state_q == S_DONE) && res_free, res_valid && last_vld_q)

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

	localparam logic [tqle_pkg::ACT_FIELD_W-1:0] ACT_NOOP = 2'd0;
	localparam logic [tqle_pkg::ACT_FIELD_W-1:0] ACT_FIRE = 2'd1;
	localparam logic [tqle_pkg::ACT_FIELD_W-1:0] ACT_UP = 2'd2;
	localparam logic [tqle_pkg::ACT_FIELD_W-1:0] ACT_DOWN = 2'd3;

	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	logic clk;
	logic arst_n = 1'b0;
	logic obs_valid = 1'b0;
	logic obs_ready;
	tqle_pkg::obs_t obs = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	tqle_pkg::res_t res;
	logic cfg_we = 1'b0;
	logic [tqle_pkg::SCALE_W-1:0] cfg_wdata = '0;

	tqle_pkg::obs_t obs_backlog[$];
	tqle_pkg::res_t res_pending[$];
	bit idle_en = 1'b1;
	int fail_count = 0;

	// predictor state
	int q_table [tqle_pkg::TABLE_DEPTH];
	int unsigned last_pair;
	bit last_pair_ok = 1'b0;
	logic [tqle_pkg::SCALE_W-1:0] discount_q = tqle_pkg::SCALE_W'(tqle_pkg::DISCOUNT_RESET);

	logic [15:0] state_pool [6] = '{16'h0000, 16'h0001, 16'h0002, 16'hFFFF, 16'h7F00, 16'h00FF};

	int send_gap = 0;
	int stall_left = 0;
	tqle_pkg::res_t drv_res;
	tqle_pkg::res_t want;

	tabular_q_learning_engine i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.obs_valid(obs_valid),
		.obs_ready(obs_ready),
		.obs(obs),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	function automatic int greedy_action(input int st);
		int best;
		int a;
		best = 0;
		for (a = 1; a < tqle_pkg::ACTION_COUNT; a++) begin
			if (q_table[a * tqle_pkg::STATE_COUNT + st] >
				q_table[best * tqle_pkg::STATE_COUNT + st]) begin
				best = a;
			end
		end
		return best;
	endfunction

	function automatic bit q_learn_predict(input tqle_pkg::obs_t o, output tqle_pkg::res_t r);
		longint alpha;
		longint gam;
		longint rwd;
		longint q;
		longint target;
		longint qbest;
		longint upd;
		int st;
		int act;
		int unsigned idx;
		st = int'(o.state_index);
		if (st >= tqle_pkg::STATE_COUNT) begin
			st = tqle_pkg::STATE_COUNT - 1;
		end
		rwd = longint'($signed(o.reward));
		alpha = (o.learning_rate > tqle_pkg::ONE_Q16) ? tqle_pkg::ONE_Q16
			: longint'(o.learning_rate);
		r = '0;
		if (o.learn_enable && last_pair_ok) begin
			q = q_table[last_pair];
			target = rwd * tqle_pkg::ONE_Q16;
			if (!o.is_final) begin
				gam = (discount_q > tqle_pkg::ONE_Q16) ? tqle_pkg::ONE_Q16
					: longint'(discount_q);
				qbest = q_table[greedy_action(st) * tqle_pkg::STATE_COUNT + st];
				target += (gam * qbest + tqle_pkg::HALF_Q16) >>> tqle_pkg::FRAC_W;
			end
			upd = q + ((alpha * (target - q) + tqle_pkg::HALF_Q16) >>> tqle_pkg::FRAC_W);
			if (upd > Q_MAX) begin
				upd = Q_MAX;
			end else if (upd < Q_MIN) begin
				upd = Q_MIN;
			end
			q_table[last_pair] = int'(upd);
		end
		if (o.is_final) begin
			last_pair_ok = 1'b0;
			return 1'b0;
		end
		act = o.explore ? int'(o.random_action) : greedy_action(st);
		if (act >= tqle_pkg::ACTION_COUNT) begin
			act = tqle_pkg::ACTION_COUNT - 1;
		end
		idx = act * tqle_pkg::STATE_COUNT + st;
		last_pair = idx;
		last_pair_ok = 1'b1;
		r.action = act[tqle_pkg::ACT_FIELD_W-1:0];
		r.action_value = q_table[idx];
		return 1'b1;
	endfunction

	function automatic tqle_pkg::obs_t mk_obs(input logic [15:0] st, input int rw,
			input int unsigned lr, input bit fin, input bit learn, input bit expl,
			input logic [1:0] ra);
		tqle_pkg::obs_t o;
		o.state_index = st;
		o.reward = rw[7:0];
		o.learning_rate = lr[tqle_pkg::SCALE_W-1:0];
		o.is_final = fin;
		o.learn_enable = learn;
		o.explore = expl;
		o.random_action = ra;
		return o;
	endfunction

	function automatic logic [tqle_pkg::SCALE_W-1:0] pick_rate();
		case ($urandom_range(0, 9))
			0: begin
				return tqle_pkg::SCALE_W'(tqle_pkg::ONE_Q16);
			end
			1: begin
				return '0;
			end
			2: begin
				return tqle_pkg::SCALE_W'($urandom_range(tqle_pkg::ONE_Q16 + 1, 131071));
			end
			3: begin
				return tqle_pkg::SCALE_W'($urandom_range(1, 255));
			end
			default: begin
				return tqle_pkg::SCALE_W'($urandom_range(0, tqle_pkg::ONE_Q16));
			end
		endcase
	endfunction

	task automatic add_episodes(input int n_items);
		int made;
		int len;
		int k;
		tqle_pkg::obs_t o;
		logic [63:0] raw;
		made = 0;
		while (made < n_items) begin
			len = $urandom_range(1, 12);
			for (k = 0; k < len; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					raw = {$urandom(), $urandom()};
					o = raw[$bits(tqle_pkg::obs_t)-1:0];
				end else begin
					o.state_index = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
						: state_pool[$urandom_range(0, 5)];
					o.reward = 8'($urandom_range(0, 255));
					o.learning_rate = pick_rate();
					o.is_final = (k == len - 1);
					o.learn_enable = ($urandom_range(0, 6) != 0);
					o.explore = ($urandom_range(0, 3) == 0);
					o.random_action = 2'($urandom_range(0, 3));
				end
				obs_backlog.push_back(o);
				made++;
			end
		end
	endtask

	task automatic drain_all();
		do begin
			@(negedge clk);
		end while (obs_backlog.size() != 0 || obs_valid || res_pending.size() != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_discount(input logic [tqle_pkg::SCALE_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		discount_q = v;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// observation driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obs_valid <= 1'b0;
			obs <= '0;
			send_gap = 0;
		end else begin
			if (obs_valid && obs_ready) begin
				if (q_learn_predict(obs, drv_res)) begin
					res_pending.push_back(drv_res);
				end
			end
			if (!(obs_valid && !obs_ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					obs_valid <= 1'b0;
				end else if (obs_backlog.size() > 0) begin
					obs <= obs_backlog.pop_front();
					obs_valid <= 1'b1;
					if (idle_en && $urandom_range(0, 4) == 0) begin
						send_gap = $urandom_range(1, 10);
					end
				end else begin
					obs_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (res_pending.size() == 0) begin
					$display("%0t unexpected result transaction: action %0d value %0d",
						$time, res.action, res.action_value);
					fail_count++;
				end else begin
					want = res_pending.pop_front();
					if (res.action !== want.action) begin
						$display("%0t action mismatch: expected %0d, actual %0d",
							$time, want.action, res.action);
						fail_count++;
					end
					if (res.action_value !== want.action_value) begin
						$display("%0t action_value mismatch: expected %0d, actual %0d",
							$time, want.action_value, res.action_value);
						fail_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 10) - 1;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	initial begin
		int i;
		logic [tqle_pkg::SCALE_W-1:0] gammas [6];
		gammas = '{17'd0, 17'd65536, 17'd131071, 17'd65537, 17'd32768,
			tqle_pkg::SCALE_W'($urandom_range(0, 131071))};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset discount, no previous pair, clamps, terminal cases
		obs_backlog.push_back(mk_obs(16'h0000, 127, 65536, 0, 1, 0, ACT_NOOP));
		obs_backlog.push_back(mk_obs(16'h0000, 127, 65536, 0, 1, 1, ACT_DOWN));
		obs_backlog.push_back(mk_obs(16'h0000, -128, 65536, 0, 1, 0, ACT_NOOP));
		obs_backlog.push_back(mk_obs(16'hFFFF, 5, 131071, 1, 1, 0, ACT_NOOP));
		obs_backlog.push_back(mk_obs(16'hFFFF, 7, 65536, 1, 1, 0, ACT_NOOP));
		obs_backlog.push_back(mk_obs(16'hFFFF, -1, 65536, 0, 0, 1, ACT_UP));
		obs_backlog.push_back(mk_obs(16'hFFFF, 100, 65536, 1, 0, 0, ACT_NOOP));
		obs_backlog.push_back(mk_obs(16'hFFFF, 100, 65536, 0, 1, 0, ACT_NOOP));
		obs_backlog.push_back(mk_obs(16'hAAAA, 127, 0, 0, 1, 1, ACT_FIRE));
		obs_backlog.push_back(mk_obs(16'h5555, -128, 1, 0, 1, 1, ACT_DOWN));
		obs_backlog.push_back(mk_obs(16'h5555, 127, 65537, 0, 1, 0, ACT_NOOP));
		obs_backlog.push_back(mk_obs(16'h5555, 64, 32768, 0, 1, 1, ACT_NOOP));
		obs_backlog.push_back(mk_obs(16'h5555, -64, 65535, 0, 1, 1, ACT_UP));
		obs_backlog.push_back(mk_obs(16'h5555, 0, 65536, 0, 1, 0, ACT_NOOP));
		obs_backlog.push_back(mk_obs(16'h0001, 1, 98304, 1, 1, 0, ACT_FIRE));
		obs_backlog.push_back(mk_obs(16'h8000, -128, 65536, 0, 0, 1, ACT_DOWN));
		obs_backlog.push_back(mk_obs(16'h8000, 127, 65536, 0, 1, 0, ACT_FIRE));
		obs_backlog.push_back(mk_obs(16'h7FFF, -128, 65536, 1, 1, 1, ACT_DOWN));
		drain_all();

		foreach (gammas[g]) begin
			write_discount(gammas[g]);
			idle_en = (g != 4);
			add_episodes(130);
			drain_all();
		end

		// full discount and step: drive one entry into positive saturation
		write_discount(tqle_pkg::SCALE_W'(tqle_pkg::ONE_Q16));
		idle_en = 1'b1;
		for (i = 0; i < 275; i++) begin
			obs_backlog.push_back(mk_obs(16'h1234, 127, 65536, 0, 1, 1, ACT_NOOP));
		end
		obs_backlog.push_back(mk_obs(16'h1234, 127, 65536, 1, 1, 0, ACT_NOOP));
		for (i = 0; i < 80; i++) begin
			obs_backlog.push_back(mk_obs(16'h4321, -128, 65536, 0, 1, 1, 2'(i)));
		end
		obs_backlog.push_back(mk_obs(16'h4321, -128, 65536, 1, 1, 0, ACT_NOOP));
		drain_all();

		write_discount(tqle_pkg::SCALE_W'(tqle_pkg::DISCOUNT_RESET));
		idle_en = 1'b0;
		add_episodes(120);
		drain_all();

		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
